// ===== hw/rtl/fctq_pkg.sv =====
// Shared constants, codes and types of the frame callback timer queue.
`default_nettype none

package fctq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int OP_W       = 2;
  localparam int ID_W       = 32;
  localparam int DELAY_W    = 32;
  localparam int TIME_W     = 63;
  localparam int REL_W      = 64;
  localparam int INTERVAL_W = 30;
  localparam int DELTA_W    = 53;
  localparam int STATUS_W   = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 30'd16666666;
  localparam logic signed [20:0]    NS_PER_MS      = 21'sd1000000;
  localparam logic [REL_W-1:0]      TIME_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [OP_W-1:0] OP_POST   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REL_W-1:0] rel;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic post;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fctq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fctq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fctq_time_alu.sv =====
// Two-stage saturating time adder: scales a post delay or takes the frame interval, then adds.
`default_nettype none

module fctq_time_alu (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire fctq_pkg::alu_req_t                     req,
  input  wire logic signed [fctq_pkg::DELAY_W-1:0]    delay,
  input  wire logic        [fctq_pkg::INTERVAL_W-1:0] interval,
  input  wire logic        [fctq_pkg::TIME_W-1:0]     base,
  output logic                                        done,
  output logic             [fctq_pkg::REL_W-1:0]      result
);

  logic                                  v1_r;
  logic                                  done_r;
  logic signed [fctq_pkg::DELTA_W-1:0]   prod;
  logic signed [fctq_pkg::DELTA_W-1:0]   delta_r;
  logic signed [fctq_pkg::REL_W:0]       sum;
  logic        [fctq_pkg::REL_W-1:0]     result_r;

  // Delay in ms times one million; the product fits in 53 signed bits.
  assign prod = fctq_pkg::DELTA_W'(delay) * fctq_pkg::DELTA_W'(fctq_pkg::NS_PER_MS);

  // The base is never negative and the delta is bounded, so only the
  // positive overflow can occur.
  assign sum = $signed({2'b00, base}) +
               $signed({{(fctq_pkg::REL_W + 1 - fctq_pkg::DELTA_W){delta_r[fctq_pkg::DELTA_W-1]}},
                        delta_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      delta_r <= req.post ? prod : fctq_pkg::DELTA_W'(interval);
    end
    if (v1_r) begin
      result_r <= (sum[fctq_pkg::REL_W:fctq_pkg::REL_W-1] == 2'b01) ?
                  fctq_pkg::TIME_MAX : sum[fctq_pkg::REL_W-1:0];
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_callback_timer_queue_core.sv =====
// Top level of the frame callback timer queue: sequencer, state and result register.
`default_nettype none

// Deadline queue of up to QUEUE_DEPTH pending callbacks, held in post order
// in one RAM of id and release time. A request is taken only while the
// sequencer is idle; the result register lets the next request in while a
// finished result still waits. A post passes through the two stages of the
// shared time adder and then the RAM write. A remove makes one pass over
// the RAM that reads one entry per cycle and writes the survivors back
// toward the front. A tick on a non-empty queue runs the time adder, then
// one counting pass, then one selection pass for every entry that fires,
// each followed by handing that result over, and, if any entry fired, a
// final compaction pass. All of these passes share the single RAM read
// port. Every pass walks the entries one per cycle, so waits on the result
// side only add the stalled cycles. There is no clearing pass after reset:
// only entries below the fill count are ever read.

module frame_callback_timer_queue_core #(
  parameter int QUEUE_DEPTH = fctq_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Configuration port.
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [fctq_pkg::INTERVAL_W-1:0] cfg_wr_data,
  // Request channel.
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic        [fctq_pkg::OP_W-1:0]       in_operation,
  input  wire logic        [fctq_pkg::ID_W-1:0]       in_callback_id,
  input  wire logic signed [fctq_pkg::DELAY_W-1:0]    in_delay_ms,
  // Result channel.
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_fired,
  output logic             [fctq_pkg::ID_W-1:0]       out_fired_id,
  output logic             [fctq_pkg::TIME_W-1:0]     out_frame_time,
  output logic             [fctq_pkg::STATUS_W-1:0]   out_status,
  output logic             [CNT_W-1:0]                out_removed_count,
  output logic             [CNT_W-1:0]                out_pending_count,
  output logic                                        out_last
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POST_ALU = 3'd1;
  localparam logic [2:0] S_TICK_ALU = 3'd2;
  localparam logic [2:0] S_COUNT    = 3'd3;
  localparam logic [2:0] S_PICK     = 3'd4;
  localparam logic [2:0] S_FIRE     = 3'd5;
  localparam logic [2:0] S_COMPACT  = 3'd6;
  localparam logic [2:0] S_RESULT   = 3'd7;

  logic [2:0]                          state_r;

  // Latched request.
  logic [fctq_pkg::OP_W-1:0]           op_r;
  logic [fctq_pkg::ID_W-1:0]           id_r;
  logic [fctq_pkg::STATUS_W-1:0]       status_r;
  logic [CNT_W-1:0]                    removed_r;

  // Architectural state.
  logic [CNT_W-1:0]                    count_r;
  logic [fctq_pkg::TIME_W-1:0]         frame_r;
  logic [fctq_pkg::INTERVAL_W-1:0]     interval_r;

  // Scan pipeline: address issued, then the registered read data processed.
  logic [CNT_W-1:0]                    scan_idx_r;
  logic                                p_vld_r;
  logic [IDX_W-1:0]                    p_idx_r;

  // Tick bookkeeping.
  logic [CNT_W-1:0]                    nfire_r;
  logic [CNT_W-1:0]                    fired_cnt_r;
  logic [CNT_W-1:0]                    kept_r;
  logic [QUEUE_DEPTH-1:0]              taken_r;
  logic                                best_found_r;
  logic [fctq_pkg::REL_W-1:0]          best_rel_r;
  logic [IDX_W-1:0]                    best_idx_r;
  logic [fctq_pkg::ID_W-1:0]           best_id_r;

  // Result register.
  logic                                out_valid_r;
  logic                                out_fired_r;
  logic [fctq_pkg::ID_W-1:0]           out_id_r;
  logic [fctq_pkg::TIME_W-1:0]         out_time_r;
  logic [fctq_pkg::STATUS_W-1:0]       out_status_r;
  logic [CNT_W-1:0]                    out_removed_r;
  logic [CNT_W-1:0]                    out_pending_r;
  logic                                out_last_r;

  // Datapath signals.
  fctq_pkg::alu_req_t                  alu_req;
  logic                                alu_done;
  logic [fctq_pkg::REL_W-1:0]          alu_result;
  fctq_pkg::entry_t                    rd_entry;
  fctq_pkg::entry_t                    wr_entry;
  logic                                wr_en;
  logic [IDX_W-1:0]                    wr_addr;
  logic                                scan_active;
  logic                                scan_issue;
  logic                                scan_done;
  logic                                due;
  logic                                pick_hit;
  logic                                keep;
  logic                                out_free;
  logic                                in_take;
  logic                                full;
  logic                                fire_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r >= CNT_W'(QUEUE_DEPTH));

  // The adder starts on an accepted post that will be stored, or on a tick
  // of a non-empty queue.
  always_comb begin
    alu_req.post  = (in_operation == fctq_pkg::OP_POST);
    alu_req.start = 1'b0;
    if (in_take) begin
      if (in_operation == fctq_pkg::OP_POST) begin
        alu_req.start = (in_callback_id != '0) && !full;
      end else if (in_operation == fctq_pkg::OP_TICK) begin
        alu_req.start = (count_r != '0);
      end
    end
  end

  fctq_time_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (alu_req),
    .delay    (in_delay_ms),
    .interval (interval_r),
    .base     (frame_r),
    .done     (alu_done),
    .result   (alu_result)
  );

  // Every pass walks entries 0 to count-1, one read per cycle.
  assign scan_active = (state_r == S_COUNT) || (state_r == S_PICK) || (state_r == S_COMPACT);
  assign scan_issue  = scan_active && (scan_idx_r < count_r);
  assign scan_done   = scan_active && !p_vld_r && (scan_idx_r == count_r);

  // An entry is due when its release time is at or before the frame time.
  // Release times are signed and may be negative.
  assign due = $signed(rd_entry.rel) <= $signed({1'b0, frame_r});

  // Strict less-than keeps the earliest post among equal release times.
  assign pick_hit = p_vld_r && !taken_r[p_idx_r] && due &&
                    (!best_found_r || ($signed(rd_entry.rel) < $signed(best_rel_r)));

  assign keep = (op_r == fctq_pkg::OP_REMOVE) ? (rd_entry.id != id_r) : !taken_r[p_idx_r];

  assign fire_last = ((fired_cnt_r + CNT_W'(1)) == nfire_r);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = count_r[IDX_W-1:0];
    wr_entry.id  = id_r;
    wr_entry.rel = alu_result;
    if (state_r == S_POST_ALU) begin
      wr_en = alu_done;
    end else if (state_r == S_COMPACT) begin
      wr_en    = p_vld_r && keep;
      wr_addr  = kept_r[IDX_W-1:0];
      wr_entry = rd_entry;
    end
  end

  fctq_ram #(
    .WIDTH (fctq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      frame_r      <= '0;
      interval_r   <= fctq_pkg::INTERVAL_RESET;
      out_valid_r  <= 1'b0;
      p_vld_r      <= 1'b0;
      scan_idx_r   <= '0;
      nfire_r      <= '0;
      fired_cnt_r  <= '0;
      kept_r       <= '0;
      best_found_r <= 1'b0;
      taken_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      p_vld_r <= scan_issue;
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            unique case (in_operation)
              fctq_pkg::OP_POST: begin
                if (in_callback_id == '0 || full) begin
                  state_r <= S_RESULT;
                end else begin
                  state_r <= S_POST_ALU;
                end
              end
              fctq_pkg::OP_REMOVE: begin
                scan_idx_r <= '0;
                kept_r     <= '0;
                state_r    <= S_COMPACT;
              end
              fctq_pkg::OP_TICK: begin
                state_r <= (count_r == '0) ? S_RESULT : S_TICK_ALU;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_POST_ALU: begin
          if (alu_done) begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_RESULT;
          end
        end
        S_TICK_ALU: begin
          if (alu_done) begin
            frame_r    <= alu_result[fctq_pkg::TIME_W-1:0];
            scan_idx_r <= '0;
            nfire_r    <= '0;
            taken_r    <= '0;
            state_r    <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (p_vld_r && due) begin
            nfire_r <= nfire_r + CNT_W'(1);
          end
          if (scan_done) begin
            if (nfire_r == '0) begin
              state_r <= S_RESULT;
            end else begin
              scan_idx_r   <= '0;
              best_found_r <= 1'b0;
              fired_cnt_r  <= '0;
              state_r      <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (pick_hit) begin
            best_found_r <= 1'b1;
          end
          if (scan_done) begin
            taken_r[best_idx_r] <= 1'b1;
            state_r             <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            fired_cnt_r  <= fired_cnt_r + CNT_W'(1);
            scan_idx_r   <= '0;
            best_found_r <= 1'b0;
            if (fire_last) begin
              kept_r  <= '0;
              state_r <= S_COMPACT;
            end else begin
              state_r <= S_PICK;
            end
          end
        end
        S_COMPACT: begin
          if (p_vld_r && keep) begin
            kept_r <= kept_r + CNT_W'(1);
          end
          if (scan_done) begin
            count_r <= kept_r;
            state_r <= (op_r == fctq_pkg::OP_REMOVE) ? S_RESULT : S_IDLE;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r      <= in_operation;
      id_r      <= in_callback_id;
      removed_r <= '0;
      if (in_operation == fctq_pkg::OP_POST && in_callback_id == '0) begin
        status_r <= fctq_pkg::STATUS_NULL;
      end else if (in_operation == fctq_pkg::OP_POST && full) begin
        status_r <= fctq_pkg::STATUS_FULL;
      end else begin
        status_r <= fctq_pkg::STATUS_OK;
      end
    end

    if (state_r == S_PICK && pick_hit) begin
      best_rel_r <= rd_entry.rel;
      best_idx_r <= p_idx_r;
      best_id_r  <= rd_entry.id;
    end

    if (scan_issue) begin
      p_idx_r <= scan_idx_r[IDX_W-1:0];
    end

    if (state_r == S_COMPACT && scan_done) begin
      removed_r <= count_r - kept_r;
    end

    // A fired result reports the count that remains once all due entries go.
    if (state_r == S_FIRE && out_free) begin
      out_fired_r   <= 1'b1;
      out_id_r      <= best_id_r;
      out_time_r    <= frame_r;
      out_status_r  <= fctq_pkg::STATUS_OK;
      out_removed_r <= '0;
      out_pending_r <= count_r - nfire_r;
      out_last_r    <= fire_last;
    end else if (state_r == S_RESULT && out_free) begin
      out_fired_r   <= 1'b0;
      out_id_r      <= '0;
      out_time_r    <= frame_r;
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_pending_r <= count_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_fired_id      = out_id_r;
  assign out_frame_time    = out_time_r;
  assign out_status        = out_status_r;
  assign out_removed_count = out_removed_r;
  assign out_pending_count = out_pending_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fctq_checker.sv =====
// Port-level checker of the frame callback timer queue and its bind statement.
`default_nettype none

module fctq_checker #(
  parameter int QUEUE_DEPTH = fctq_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   out_valid,
  input wire logic                                   out_stall,
  input wire logic                                   out_fired,
  input wire logic        [fctq_pkg::ID_W-1:0]       out_fired_id,
  input wire logic        [fctq_pkg::TIME_W-1:0]     out_frame_time,
  input wire logic        [fctq_pkg::STATUS_W-1:0]   out_status,
  input wire logic        [CNT_W-1:0]                out_removed_count,
  input wire logic        [CNT_W-1:0]                out_pending_count,
  input wire logic                                   out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fired_id) &&
      $stable(out_frame_time) && $stable(out_last) && $stable(out_pending_count))
    else $error("result changed while stalled");

  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_last)
    else $error("result without a fired callback is not the last one");

  a_fired_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_status == fctq_pkg::STATUS_OK &&
      out_removed_count == '0 && out_fired_id != '0)
    else $error("fired result carries bad fields");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= CNT_W'(QUEUE_DEPTH) &&
      out_removed_count <= CNT_W'(QUEUE_DEPTH))
    else $error("count beyond queue depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fctq_pkg::STATUS_FULL |->
      out_pending_count == CNT_W'(QUEUE_DEPTH))
    else $error("post dropped while queue not full");

endmodule

bind frame_callback_timer_queue_core fctq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fctq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_fired         (out_fired),
  .out_fired_id      (out_fired_id),
  .out_frame_time    (out_frame_time),
  .out_status        (out_status),
  .out_removed_count (out_removed_count),
  .out_pending_count (out_pending_count),
  .out_last          (out_last)
);

`default_nettype wire

// ===== test/tb_frame_callback_timer_queue_core.sv =====
// Self-checking testbench of the frame callback timer queue core.
`timescale 1ns / 1ps

module tb_frame_callback_timer_queue_core;

  // The block keeps at most this many pending callbacks.
  localparam int DEPTH = fctq_pkg::DEFAULT_QUEUE_DEPTH;
  // Milliseconds of post delay are turned into nanoseconds of release time.
  localparam longint MS_TO_NS = 1000000;
  localparam longint FRAME_TIME_MAX = longint'(fctq_pkg::TIME_MAX);
  // Operation code 3 has no function; the block answers it with a plain result.
  localparam logic [fctq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // A tick over sixteen due entries is a long operation, and the receiver may
  // add its own stalls on top, so only a quiet run this long means a hang.
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles allowed after the last result of a tick for the compaction pass.
  localparam int SETTLE_CYCLES = 60;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                          fired;
    logic [fctq_pkg::ID_W-1:0]     fired_id;
    logic [fctq_pkg::TIME_W-1:0]   frame_time;
    logic [fctq_pkg::STATUS_W-1:0] status;
    logic [4:0]                    removed;
    logic [4:0]                    pending;
    logic                          last;
  } callback_report_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Stimulus side of the block; every input starts at a known value.
  logic                                  cfg_wr_en = 1'b0;
  logic [fctq_pkg::INTERVAL_W-1:0]       cfg_wr_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [fctq_pkg::OP_W-1:0]             in_operation = fctq_pkg::OP_POST;
  logic [fctq_pkg::ID_W-1:0]             in_callback_id = '0;
  logic signed [fctq_pkg::DELAY_W-1:0]   in_delay_ms = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic                                  out_fired;
  logic [fctq_pkg::ID_W-1:0]             out_fired_id;
  logic [fctq_pkg::TIME_W-1:0]           out_frame_time;
  logic [fctq_pkg::STATUS_W-1:0]         out_status;
  logic [4:0]                            out_removed_count;
  logic [4:0]                            out_pending_count;
  logic                                  out_last;

  frame_callback_timer_queue_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_callback_id    (in_callback_id),
    .in_delay_ms       (in_delay_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired         (out_fired),
    .out_fired_id      (out_fired_id),
    .out_frame_time    (out_frame_time),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_pending_count (out_pending_count),
    .out_last          (out_last)
  );

  // Shadow copy of the timer queue. Entries stay in post order so that the
  // earliest post wins a tie between equal release times.
  logic [fctq_pkg::INTERVAL_W-1:0] interval_ns = fctq_pkg::INTERVAL_RESET;
  int                              entries = 0;
  logic [fctq_pkg::ID_W-1:0]       queued_ids [DEPTH];
  longint                          queued_release [DEPTH];
  longint                          now_ns = 0;

  // Results the block still owes, oldest first.
  callback_report_t callback_reports [$];
  int               fail_count = 0;

  // Sender pacing: bursts of random length separated by random gaps, unless
  // a test asks for a gapless stretch.
  int   burst_left = 0;
  logic sender_gapless = 1'b0;

  // Receiver pacing and the long hold-off, requested by flipping the token.
  logic        hold_token = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_phase = 0;
  int          idle_cycles = 0;

  // Adds a time offset and clamps at the largest signed 64-bit value instead
  // of wrapping. The base never goes negative, so only the top can overflow.
  function automatic longint sat_sum(input longint base, input longint delta);
    if (delta > 0 && base > FRAME_TIME_MAX - delta) begin
      return FRAME_TIME_MAX;
    end
    return base + delta;
  endfunction

  function automatic callback_report_t make_report(
      input logic fired,
      input logic [fctq_pkg::ID_W-1:0] id,
      input logic [fctq_pkg::STATUS_W-1:0] status,
      input int removed,
      input logic last);
    callback_report_t rep;
    rep.fired      = fired;
    rep.fired_id   = id;
    rep.frame_time = now_ns[fctq_pkg::TIME_W-1:0];
    rep.status     = status;
    rep.removed    = removed[4:0];
    rep.pending    = entries[4:0];
    rep.last       = last;
    return rep;
  endfunction

  // Appends one owed result behind the ones already waiting.
  function automatic void owe_report(input callback_report_t rep);
    callback_reports.insert(callback_reports.size(), rep);
  endfunction

  // Applies one accepted request to the shadow queue and records the results
  // it must produce, in the order the block has to deliver them.
  task automatic apply_timer_request(input logic [fctq_pkg::OP_W-1:0] op,
                                     input logic [fctq_pkg::ID_W-1:0] id,
                                     input logic signed [fctq_pkg::DELAY_W-1:0] delay);
    logic [fctq_pkg::STATUS_W-1:0] status;
    longint                        delay_ns;
    bit                            taken [DEPTH];
    logic [fctq_pkg::ID_W-1:0]     order [DEPTH];
    int                            nfire;
    int                            best;
    int                            kept;
    int                            count_at_start;
    status = fctq_pkg::STATUS_OK;
    nfire = 0;
    kept = 0;
    count_at_start = entries;
    delay_ns = longint'(delay);
    case (op)
      fctq_pkg::OP_POST: begin
        if (id == '0) begin
          status = fctq_pkg::STATUS_NULL;
        end else if (entries >= DEPTH) begin
          status = fctq_pkg::STATUS_FULL;
        end else begin
          queued_ids[entries] = id;
          queued_release[entries] = sat_sum(now_ns, delay_ns * MS_TO_NS);
          entries++;
        end
        owe_report(make_report(1'b0, '0, status, 0, 1'b1));
      end
      fctq_pkg::OP_REMOVE: begin
        for (int i = 0; i < entries; i++) begin
          if (queued_ids[i] != id) begin
            queued_ids[kept] = queued_ids[i];
            queued_release[kept] = queued_release[i];
            kept++;
          end
        end
        entries = kept;
        owe_report(make_report(1'b0, '0, fctq_pkg::STATUS_OK, count_at_start - kept, 1'b1));
      end
      fctq_pkg::OP_TICK: begin
        // An empty queue leaves the frame time where it is.
        if (entries > 0) begin
          now_ns = sat_sum(now_ns, longint'(interval_ns));
          for (int i = 0; i < DEPTH; i++) begin
            taken[i] = 1'b0;
          end
          // Repeatedly pick the earliest due entry; the strict compare keeps
          // the earlier post on a tie.
          do begin
            best = -1;
            for (int i = 0; i < entries; i++) begin
              if (!taken[i] && queued_release[i] <= now_ns) begin
                if (best < 0 || queued_release[i] < queued_release[best]) begin
                  best = i;
                end
              end
            end
            if (best >= 0) begin
              taken[best] = 1'b1;
              order[nfire] = queued_ids[best];
              nfire++;
            end
          end while (best >= 0);
          for (int i = 0; i < entries; i++) begin
            if (!taken[i]) begin
              queued_ids[kept] = queued_ids[i];
              queued_release[kept] = queued_release[i];
              kept++;
            end
          end
          entries = kept;
        end
        // The pending count on every fired result is the count after the
        // whole tick, not a running count.
        if (nfire == 0) begin
          owe_report(make_report(1'b0, '0, fctq_pkg::STATUS_OK, 0, 1'b1));
        end else begin
          for (int k = 0; k < nfire; k++) begin
            owe_report(make_report(1'b1, order[k], fctq_pkg::STATUS_OK, 0,
                                   k == nfire - 1));
          end
        end
      end
      default: begin
        owe_report(make_report(1'b0, '0, fctq_pkg::STATUS_OK, 0, 1'b1));
      end
    endcase
  endtask

  // Offers one request, holds it until the block takes it, then applies the
  // sender's burst and gap pacing. Valid is only lowered when a gap follows,
  // so back-to-back requests never see valid drop and rise in one step.
  task automatic send_request(input logic [fctq_pkg::OP_W-1:0] op,
                              input logic [fctq_pkg::ID_W-1:0] id,
                              input logic signed [fctq_pkg::DELAY_W-1:0] delay);
    int gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_callback_id <= id;
    in_delay_ms <= delay;
    do begin
      @(posedge clk);
    end while (in_stall);
    apply_timer_request(op, id, delay);
    if (sender_gapless) begin
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 9);
      burst_left = $urandom_range(0, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every owed result has arrived, then lets a tick's trailing
  // compaction pass finish so that the block is truly idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (callback_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_frame_interval(input logic [fctq_pkg::INTERVAL_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    interval_ns = value;
  endtask

  // Mostly a small pool of ids so that removes and repeated posts collide,
  // with some fully random ids and some null ones.
  function automatic logic [fctq_pkg::ID_W-1:0] pick_callback_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 8);
    end else if (roll < 92) begin
      return $urandom;
    end
    return '0;
  endfunction

  // Most delays land within a few frames of the current interval, so ticks
  // keep firing. The rest are small negatives or full-range values on every bit.
  function automatic logic signed [fctq_pkg::DELAY_W-1:0] pick_delay_ms();
    int span_ms;
    int roll;
    span_ms = int'((longint'(interval_ns) * 3) / MS_TO_NS);
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      return $urandom_range(0, span_ms + 2) - 2;
    end else if (roll < 90) begin
      return $urandom;
    end
    return -$urandom_range(0, 1000);
  endfunction

  // A random mix that stays well-formed most of the time: posts with live
  // ids, ticks that drain them and removes aimed mostly at queued ids.
  task automatic run_random_traffic(input int useful_items);
    int                        done;
    int                        roll;
    logic [fctq_pkg::ID_W-1:0] id;
    done = 0;
    while (done < useful_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        id = pick_callback_id();
        send_request(fctq_pkg::OP_POST, id, pick_delay_ms());
        if (id != '0) begin
          done++;
        end
      end else if (roll < 70) begin
        send_request(fctq_pkg::OP_TICK, $urandom, $urandom);
        done++;
      end else if (roll < 92) begin
        if (entries > 0 && $urandom_range(0, 9) < 7) begin
          id = queued_ids[$urandom_range(0, entries - 1)];
        end else begin
          id = pick_callback_id();
        end
        send_request(fctq_pkg::OP_REMOVE, id, $urandom);
        done++;
      end else begin
        send_request(OP_UNUSED, $urandom, $urandom);
      end
    end
  endtask

  // Every operation once, the null and unused cases, the extremes of the
  // delay and id, a tick on an empty queue, a tick with nothing due and a
  // tick that fires several entries including a tie in release time.
  task automatic test_directed_operations();
    send_request(fctq_pkg::OP_TICK, '0, '0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(fctq_pkg::OP_POST, '0, 32'sd5);
    send_request(fctq_pkg::OP_REMOVE, '0, '0);
    send_request(fctq_pkg::OP_POST, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    send_request(fctq_pkg::OP_POST, 32'd5, 32'sh8000_0000);
    send_request(fctq_pkg::OP_POST, 32'd7, 32'sd16);
    send_request(fctq_pkg::OP_POST, 32'd5, 32'sd16);
    send_request(fctq_pkg::OP_POST, 32'd3, 32'sd17);
    send_request(fctq_pkg::OP_POST, 32'd7, 32'sd0);
    // With the reset interval of about 16.7 ms, the next tick fires all but
    // the 17 ms entry and the far-future one.
    send_request(fctq_pkg::OP_TICK, '0, '0);
    send_request(fctq_pkg::OP_TICK, '0, '0);
    send_request(fctq_pkg::OP_TICK, '0, '0);
    send_request(fctq_pkg::OP_POST, 32'h1234_5678, -32'sd1);
    send_request(fctq_pkg::OP_POST, 32'h1234_5678, 32'sd5);
    send_request(fctq_pkg::OP_REMOVE, 32'h1234_5678, '0);
    send_request(fctq_pkg::OP_REMOVE, 32'hAAAA_AAAA, '0);
    send_request(fctq_pkg::OP_REMOVE, 32'hFFFF_FFFF, '0);
    send_request(fctq_pkg::OP_TICK, '0, '0);
    wait_drained();
  endtask

  // Fills the queue with due entries, hits the full and null cases on a full
  // queue, then fires all sixteen at once while the receiver holds off for a
  // long stretch and the sender keeps offering requests.
  task automatic test_full_queue_backpressure();
    write_frame_interval(fctq_pkg::INTERVAL_RESET);
    for (int k = 0; k < DEPTH; k++) begin
      send_request(fctq_pkg::OP_POST, 32'h100 + (k % 5), -(k % 4));
    end
    send_request(fctq_pkg::OP_POST, 32'hDEAD_0001, '0);
    send_request(fctq_pkg::OP_POST, '0, '0);
    sender_gapless = 1'b1;
    hold_token <= ~hold_token;
    send_request(fctq_pkg::OP_TICK, '0, '0);
    send_request(fctq_pkg::OP_POST, 32'h0000_0001, 32'sd10);
    send_request(fctq_pkg::OP_POST, 32'h0000_0002, -32'sd3);
    send_request(fctq_pkg::OP_REMOVE, 32'h0000_0001, '0);
    send_request(fctq_pkg::OP_TICK, '0, '0);
    sender_gapless = 1'b0;
    wait_drained();
  endtask

  // Random traffic under several frame intervals, both ends of the range
  // among them. The last stretch runs the sender without gaps.
  task automatic test_random_intervals();
    write_frame_interval(30'd1);
    run_random_traffic(15);
    wait_drained();
    write_frame_interval(30'd1_000_000_000);
    run_random_traffic(15);
    wait_drained();
    write_frame_interval(fctq_pkg::INTERVAL_W'($urandom_range(1, 1_000_000_000)));
    run_random_traffic(15);
    wait_drained();
    write_frame_interval(fctq_pkg::INTERVAL_RESET);
    sender_gapless = 1'b1;
    run_random_traffic(15);
    sender_gapless = 1'b0;
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_callback_report();
    callback_report_t want;
    if (callback_reports.size() == 0) begin
      $error("result delivered with no request outstanding");
      fail_count++;
    end else begin
      want = callback_reports.pop_front();
      check_field("fired", 64'(want.fired), 64'(out_fired));
      check_field("fired_id", 64'(want.fired_id), 64'(out_fired_id));
      check_field("frame_time", 64'(want.frame_time), 64'(out_frame_time));
      check_field("status", 64'(want.status), 64'(out_status));
      check_field("removed_count", 64'(want.removed), 64'(out_removed_count));
      check_field("pending_count", 64'(want.pending), 64'(out_pending_count));
      check_field("last", 64'(want.last), 64'(out_last));
    end
  endtask

  // Every accepted result is compared with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_callback_report();
    end
  end

  // Receiver pacing: a long hold-off when the token flips, otherwise a mode
  // that changes at random intervals, including stretches with no stall.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:     out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Watchdog: a long run of cycles with no transfer on any port is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_operations();
    test_full_queue_backpressure();
    test_random_intervals();
    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
